@@ hdl/tsn_pkg.sv @@
package tsn_pkg;

  // Most bytes that one transaction can produce.
  localparam int unsigned MaxOut = 5;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);

  // Default depth of the command queue between the front and back parts.
  localparam int unsigned QueueDepthDef = 2;

  // Class of the last emitted byte.
  localparam logic [1:0] ClsNone  = 2'd0;
  localparam logic [1:0] ClsSpace = 2'd1;
  localparam logic [1:0] ClsWord  = 2'd2;
  localparam logic [1:0] ClsSym   = 2'd3;

  // Item kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChF     = 8'h46;

  // One decoded transaction: the bytes to send, in order, and their count.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
    logic                   done;
  } tsn_cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c inside {[ChTab:ChCr]});
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic forms_pair(input logic [7:0] a, input logic [7:0] b);
    logic eq_pair;
    logic dbl_pair;
    eq_pair  = (b == ChEq) && (a inside {ChEq, ChBang, ChLt, ChGt});
    dbl_pair = (a == b) && (a inside {ChPlus, ChMinus, ChAmp, ChBar});
    return eq_pair || dbl_pair;
  endfunction

  function automatic logic [1:0] class_of(input logic [7:0] c);
    logic [1:0] cls;
    if (c == ChSpace) begin
      cls = ClsSpace;
    end else if (is_word(c)) begin
      cls = ClsWord;
    end else begin
      cls = ClsSym;
    end
    return cls;
  endfunction

endpackage

@@ hdl/token_spacing_normalizer.sv @@
// Token spacing normalizer. Source text enters one byte per transaction
// (kind_i = 0) and the stream is closed by an end transaction (kind_i = 1);
// normalized text leaves one byte per transaction on a queue-style port.
// Whitespace runs collapse to one space, words and symbols are separated by a
// space, every symbol is followed by a space, and the operators == != <= >=
// ++ -- && || stay together. A symbol waits for the next byte before it is
// sent, so its bytes appear with the following transaction. The end
// transaction flushes a waiting symbol, sends " EOF" (without the leading
// space when the last byte sent was a space), marks the final 'F' with
// stream_done_o and returns the block to its reset state. run_last_o marks the
// last output byte caused by each input transaction; inputs that produce no
// output (leading whitespace, a symbol being held) produce no transaction.
// Rate: an input is accepted whenever the command queue has room, and the
// output side sends one byte per cycle while the reader keeps popping; an
// input produces zero to five output bytes, typically one. The single
// byte-wide output register limits the output side to one byte at a time.
// When the block is idle, the first byte of an input passes through the
// queue entry, the command register and the output byte register before it
// appears.
module token_spacing_normalizer
  import tsn_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);

  logic     accept;
  logic     cmd_valid;
  tsn_cmd_t cmd;
  logic     q_full, q_empty, q_rd;
  tsn_cmd_t q_data;

  // The front part classifies a byte the moment it is accepted, so the
  // spacing state is always current; only the queue depth limits acceptance.
  assign accept = push && !q_full;
  assign full   = q_full;

  tsn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  tsn_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  // The back part expands each queued command into output bytes.
  tsn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_data),
    .q_rd_o        (q_rd),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

endmodule

@@ hdl/tsn_front.sv @@
module tsn_front
  import tsn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  output logic       cmd_valid_o,
  output tsn_cmd_t   cmd_o
);

  logic [1:0] last_class_q, last_class_d;
  logic       held_valid_q, held_valid_d;
  logic [7:0] held_sym_q, held_sym_d;

  // Work out every byte this transaction produces and the state it leaves.
  always_comb begin
    logic [CntW-1:0] n;
    logic [1:0]      cls;
    logic [MaxOut-1:0][7:0] b;
    logic            done;
    n    = '0;
    cls  = last_class_q;
    b    = '0;
    done = 1'b0;
    held_valid_d = held_valid_q;
    held_sym_d   = held_sym_q;

    if (held_valid_q && (kind_i == KindByte) && forms_pair(held_sym_q, ch_i)) begin
      b[n] = held_sym_q; n = n + 1'b1;
      b[n] = ch_i;       n = n + 1'b1;
      b[n] = ChSpace;    n = n + 1'b1;
      cls          = ClsSpace;
      held_valid_d = 1'b0;
      held_sym_d   = '0;
    end else begin
      if (held_valid_q) begin
        b[n] = held_sym_q; n = n + 1'b1;
        b[n] = ChSpace;    n = n + 1'b1;
        cls          = ClsSpace;
        held_valid_d = 1'b0;
        held_sym_d   = '0;
      end
      if (kind_i == KindEnd) begin
        if (cls != ClsSpace) begin
          b[n] = ChSpace; n = n + 1'b1;
        end
        b[n] = ChE; n = n + 1'b1;
        b[n] = ChO; n = n + 1'b1;
        b[n] = ChF; n = n + 1'b1;
        done = 1'b1;
        // The stream starts over after the end marker.
        cls          = ClsNone;
        held_valid_d = 1'b0;
        held_sym_d   = '0;
      end else if (is_ws(ch_i)) begin
        if (cls == ClsWord || cls == ClsSym) begin
          b[n] = ChSpace; n = n + 1'b1;
          cls  = ClsSpace;
        end
      end else if (is_word(ch_i)) begin
        if (cls == ClsSym) begin
          b[n] = ChSpace; n = n + 1'b1;
        end
        b[n] = ch_i; n = n + 1'b1;
        cls  = class_of(ch_i);
      end else begin
        if (cls == ClsWord || cls == ClsSym) begin
          b[n] = ChSpace; n = n + 1'b1;
          cls  = ClsSpace;
        end
        held_valid_d = 1'b1;
        held_sym_d   = ch_i;
      end
    end

    last_class_d = cls;
    cmd_o.bytes  = b;
    cmd_o.count  = n;
    cmd_o.done   = done;
    cmd_valid_o  = accept_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_class_q <= ClsNone;
      held_valid_q <= 1'b0;
      held_sym_q   <= '0;
    end else if (accept_i) begin
      last_class_q <= last_class_d;
      held_valid_q <= held_valid_d;
      held_sym_q   <= held_sym_d;
    end
  end

endmodule

@@ hdl/tsn_cmd_queue.sv @@
module tsn_cmd_queue
  import tsn_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  tsn_cmd_t wr_data_i,
  output logic     full_o,
  input  logic     rd_i,
  output tsn_cmd_t rd_data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  tsn_cmd_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntQW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/tsn_back.sv @@
module tsn_back
  import tsn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  tsn_cmd_t   q_data_i,
  output logic       q_rd_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);

  tsn_cmd_t        cmd_q;
  logic            busy_q;
  logic [CntW-1:0] idx_q;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic            olast_q, odone_q;
  logic            out_adv, emit, is_last;

  assign out_adv = !ovalid_q || pop_i;
  assign emit    = busy_q && out_adv;
  assign is_last = (idx_q == cmd_q.count - 1'b1);
  // Take a new command when idle, or when the current one sends its last byte.
  assign q_rd_o  = !q_empty_i && (!busy_q || (emit && is_last));

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cmd_q <= q_data_i;
    end
    if (emit) begin
      obyte_q <= cmd_q.bytes[idx_q];
      olast_q <= is_last;
      odone_q <= is_last && cmd_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (q_rd_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (out_adv) begin
        ovalid_q <= emit;
      end
    end
  end

  assign empty_o       = !ovalid_q;
  assign out_byte_o    = obyte_q;
  assign run_last_o    = olast_q;
  assign stream_done_o = odone_q;

endmodule
